// File: sv/tlqe_pkg.sv
package tlqe_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int UNIT_ONE            = 16384;
  localparam int QUEUE_DEPTH         = 2;

  localparam int PADDR_W = 2;
  localparam logic [PADDR_W-1:0] ADDR_LINE_THICKNESS = '0;
  localparam logic [30:0] THICK_RESET = 31'd65536;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [15:0] unit_t;
  typedef logic signed [33:0] wvec_t;

  // One expanded segment, handed from the front to the back
  typedef struct packed {
    coord_t [2:0] a;
    coord_t [2:0] b;
    coord_t [2:0] off;
    unit_t  [2:0] nrm;
  } seg_t;

endpackage

// File: sv/tlqe_norm.sv
module tlqe_norm import tlqe_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  wvec_t [2:0]   v,
  output logic          done,
  output unit_t [2:0]   u
);

  localparam logic [2:0] NS_IDLE  = 3'd0;
  localparam logic [2:0] NS_SCALE = 3'd1;
  localparam logic [2:0] NS_SQ    = 3'd2;
  localparam logic [2:0] NS_SQRT  = 3'd3;
  localparam logic [2:0] NS_DINIT = 3'd4;
  localparam logic [2:0] NS_DIV   = 3'd5;

  logic [2:0]        state;
  logic [2:0][33:0]  m;
  logic [2:0]        neg;
  logic [1:0]        cnt;
  logic [63:0]       acc;
  logic [63:0]       n;
  logic [63:0]       r;
  logic [63:0]       rbit;
  logic [31:0]       len;
  logic [45:0]       rem;
  logic [45:0]       dv;
  logic [14:0]       q;
  logic [3:0]        dstep;

  logic [33:0] mx;
  logic [63:0] acc_next;
  logic [63:0] trial;
  logic        take;
  logic [63:0] r_next;
  logic        ge;
  logic [14:0] q_next;
  logic [14:0] q_cap;
  logic        vzero;

  always_comb begin
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    acc_next = acc + {4'b0, 60'(m[cnt][29:0]) * 60'(m[cnt][29:0])};
    trial    = r + rbit;
    take     = n >= trial;
    r_next   = take ? ((r >> 1) + rbit) : (r >> 1);
    ge       = rem >= dv;
    q_next   = {q[13:0], ge};
    q_cap    = (q_next > 15'(UNIT_ONE)) ? 15'(UNIT_ONE) : q_next;
    vzero    = (v[0] == '0) && (v[1] == '0) && (v[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= NS_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        NS_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              m[i]   <= v[i][33] ? 34'(-v[i]) : 34'(v[i]);
              neg[i] <= v[i][33];
            end
            if (vzero) begin
              u    <= '0;
              done <= 1'b1;
            end else begin
              state <= NS_SCALE;
            end
          end
        end
        NS_SCALE: begin
          if (mx >= 34'(1) << 30) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else if (mx < 34'(1) << 29) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end else begin
            acc   <= '0;
            cnt   <= '0;
            state <= NS_SQ;
          end
        end
        NS_SQ: begin
          acc <= acc_next;
          cnt <= cnt + 2'd1;
          if (cnt == 2'd2) begin
            n     <= acc_next;
            r     <= '0;
            rbit  <= 64'd1 << 62;
            state <= NS_SQRT;
          end
        end
        NS_SQRT: begin
          if (take) n <= n - trial;
          r    <= r_next;
          rbit <= rbit >> 2;
          if (rbit == 64'd1) begin
            len   <= r_next[31:0];
            cnt   <= '0;
            state <= NS_DINIT;
          end
        end
        NS_DINIT: begin
          rem   <= {2'b0, m[cnt][29:0], 14'b0} + {15'b0, len[31:1]};
          dv    <= {len, 14'b0};
          q     <= '0;
          dstep <= '0;
          state <= NS_DIV;
        end
        NS_DIV: begin
          if (ge) rem <= rem - dv;
          dv    <= dv >> 1;
          q     <= q_next;
          dstep <= dstep + 4'd1;
          if (dstep == 4'd14) begin
            u[cnt] <= neg[cnt] ? -unit_t'({1'b0, q_cap}) : unit_t'({1'b0, q_cap});
            if (cnt == 2'd2) begin
              done  <= 1'b1;
              state <= NS_IDLE;
            end else begin
              cnt   <= cnt + 2'd1;
              state <= NS_DINIT;
            end
          end
        end
        default: state <= NS_IDLE;
      endcase
    end
  end

endmodule

// File: sv/tlqe_front.sv
module tlqe_front import tlqe_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  coord_t [2:0]  pa,
  input  coord_t [2:0]  pb,
  input  logic [30:0]   thickness,
  input  logic          q_full,
  output logic          push,
  output seg_t          seg
);

  localparam logic [63:0] THR_DIR   = 64'd1 << COORD_FRAC_BITS;
  localparam logic [63:0] THR_MID   = 64'd1 << (COORD_FRAC_BITS + 2);
  localparam logic [63:0] THR_CROSS = 64'd1 << (56 - COORD_FRAC_BITS);
  localparam logic [30:0] THICK_MIN =
    31'(((64'd1 << COORD_FRAC_BITS) + 64'd50) / 64'd100);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_NZ    = 3'd1;
  localparam logic [2:0] ST_NORM  = 3'd2;
  localparam logic [2:0] ST_CROSS = 3'd3;
  localparam logic [2:0] ST_OFF   = 3'd4;
  localparam logic [2:0] ST_PUSH  = 3'd5;

  localparam logic [1:0] PH_DIR    = 2'd0;
  localparam logic [1:0] PH_MID    = 2'd1;
  localparam logic [1:0] PH_SIDE   = 2'd2;
  localparam logic [1:0] PH_UPSIDE = 2'd3;

  logic [2:0]    state;
  logic [1:0]    ph;
  logic [1:0]    cnt;
  coord_t [2:0]  a;
  coord_t [2:0]  b;
  wvec_t  [2:0]  vec;
  unit_t  [2:0]  dir;
  unit_t  [2:0]  nrm;
  unit_t  [2:0]  side;
  coord_t [2:0]  off;
  logic [63:0]   acc;
  logic          big;
  logic          nstart;

  logic          ndone;
  unit_t [2:0]   nres;

  tlqe_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (nstart),
    .v     (vec),
    .done  (ndone),
    .u     (nres)
  );

  // near-zero test, one component per cycle
  wvec_t        cur;
  logic [33:0]  curmag;
  logic [63:0]  acc_next;
  logic         big_next;
  logic [63:0]  thr;
  logic         is_zero;

  // cross product, one component per cycle
  unit_t [2:0]        lhs;
  logic signed [15:0] x1, y1, x2, y2;
  logic signed [31:0] p1, p2;
  wvec_t              cr;

  // offset, one component per cycle
  logic [30:0]        thick_c;
  logic signed [15:0] sd;
  logic [15:0]        smag;
  logic [46:0]        prod;
  logic [31:0]        mo;

  always_comb begin
    cur      = vec[cnt];
    curmag   = cur[33] ? 34'(-cur) : 34'(cur);
    acc_next = acc + {4'b0, 60'(curmag[29:0]) * 60'(curmag[29:0])};
    big_next = big | (|curmag[33:30]);
    case (ph)
      PH_DIR:  thr = THR_DIR;
      PH_MID:  thr = THR_MID;
      default: thr = THR_CROSS;
    endcase
    is_zero = !big_next && (acc_next < thr);

    if (ph == PH_UPSIDE) begin
      lhs[0] = '0;
      lhs[1] = '0;
      lhs[2] = unit_t'(UNIT_ONE);
    end else begin
      lhs = nrm;
    end
    case (cnt)
      2'd0: begin
        x1 = lhs[1]; y1 = dir[2]; x2 = lhs[2]; y2 = dir[1];
      end
      2'd1: begin
        x1 = lhs[2]; y1 = dir[0]; x2 = lhs[0]; y2 = dir[2];
      end
      default: begin
        x1 = lhs[0]; y1 = dir[1]; x2 = lhs[1]; y2 = dir[0];
      end
    endcase
    p1 = x1 * y1;
    p2 = x2 * y2;
    cr = 34'(p1) - 34'(p2);

    thick_c = (thickness < THICK_MIN) ? THICK_MIN : thickness;
    sd      = side[cnt];
    smag    = sd[15] ? 16'(-sd) : 16'(sd);
    prod    = 47'(smag[14:0]) * 47'(thick_c) + 47'(1 << 14);
    mo      = prod[46:15];
  end

  assign in_stall = (state != ST_IDLE);
  assign push     = (state == ST_PUSH) && !q_full;
  assign seg      = '{a: a, b: b, off: off, nrm: nrm};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      nstart <= 1'b0;
    end else begin
      nstart <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            a <= pa;
            b <= pb;
            for (int i = 0; i < 3; i++) begin
              vec[i] <= {{2{pb[i][31]}}, pb[i]} - {{2{pa[i][31]}}, pa[i]};
            end
            ph    <= PH_DIR;
            cnt   <= '0;
            acc   <= '0;
            big   <= 1'b0;
            state <= ST_NZ;
          end
        end
        ST_NZ: begin
          acc <= acc_next;
          big <= big_next;
          cnt <= cnt + 2'd1;
          if (cnt == 2'd2) begin
            cnt <= '0;
            if (!is_zero) begin
              nstart <= 1'b1;
              state  <= ST_NORM;
            end else begin
              case (ph)
                PH_MID: begin
                  nrm[0] <= '0;
                  nrm[1] <= '0;
                  nrm[2] <= unit_t'(UNIT_ONE);
                  ph     <= PH_SIDE;
                  state  <= ST_CROSS;
                end
                PH_SIDE: begin
                  ph    <= PH_UPSIDE;
                  state <= ST_CROSS;
                end
                default: state <= ST_IDLE;  // degenerate segment or side
              endcase
            end
          end
        end
        ST_NORM: begin
          if (ndone) begin
            case (ph)
              PH_DIR: begin
                dir <= nres;
                for (int i = 0; i < 3; i++) begin
                  vec[i] <= {{2{b[i][31]}}, b[i]} + {{2{a[i][31]}}, a[i]};
                end
                acc   <= '0;
                big   <= 1'b0;
                ph    <= PH_MID;
                state <= ST_NZ;
              end
              PH_MID: begin
                nrm   <= nres;
                ph    <= PH_SIDE;
                state <= ST_CROSS;
              end
              default: begin
                side  <= nres;
                state <= ST_OFF;
              end
            endcase
          end
        end
        ST_CROSS: begin
          vec[cnt] <= cr;
          cnt      <= cnt + 2'd1;
          if (cnt == 2'd2) begin
            cnt   <= '0;
            acc   <= '0;
            big   <= 1'b0;
            state <= ST_NZ;
          end
        end
        ST_OFF: begin
          off[cnt] <= sd[15] ? -coord_t'(mo) : coord_t'(mo);
          cnt      <= cnt + 2'd1;
          if (cnt == 2'd2) begin
            cnt   <= '0;
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!q_full) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sv/tlqe_queue.sv
module tlqe_queue import tlqe_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  seg_t  wdata,
  output logic  full,
  input  logic  pop,
  output seg_t  rdata,
  output logic  empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  seg_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + PW'(1);
      if (pop)  rp <= (rp == PW'(QUEUE_DEPTH - 1)) ? '0 : rp + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

// File: sv/tlqe_back.sv
module tlqe_back import tlqe_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  seg_t          q_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output coord_t [2:0]  vertex,
  output unit_t  [2:0]  normal,
  output logic [1:0]    corner,
  output logic          last
);

  seg_t        cur;
  logic        cur_valid;
  logic [1:0]  k;
  logic        load;
  logic        plus;
  coord_t [2:0] pos;

  assign pop  = !cur_valid && !q_empty;
  assign load = cur_valid && (!out_valid || !out_stall);
  assign plus = (k == 2'd1) || (k == 2'd2);

  always_comb begin
    logic signed [33:0] p;
    logic signed [33:0] o;
    logic signed [33:0] sum;
    for (int i = 0; i < 3; i++) begin
      p   = k[1] ? 34'(cur.b[i]) : 34'(cur.a[i]);
      o   = 34'(cur.off[i]);
      sum = plus ? (p + o) : (p - o);
      if (sum > 34'sd2147483647)        pos[i] = 32'sh7fffffff;
      else if (sum < -34'sd2147483648)  pos[i] = 32'sh80000000;
      else                              pos[i] = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_data;
    if (load) begin
      vertex <= pos;
      normal <= cur.nrm;
      corner <= k;
      last   <= (k == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        k         <= '0;
      end
      if (load) begin
        out_valid <= 1'b1;
        k         <= k + 2'd1;
        if (k == 2'd3) cur_valid <= 1'b0;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/thick_line_quad_expander_core.sv
// Expands a 3D segment (A, B in signed fixed point) into the four corners of a flat
// ribbon quad: A-o, A+o, B+o, B-o, with triangles (0,1,2) and (0,2,3). Degenerate
// segments or sides produce no corners. The front classifies and solves one segment
// at a time; its time is set by the shared normalizer (bit-serial shift, 32-step
// square root and a 15-step divide per component, run up to three times). A
// two-entry queue lets the front take the next segment while the back emits the
// previous one, four corner transfers from an output register. line_thickness
// lives at address 0 and is clamped below at 0.01.
module thick_line_quad_expander_core import tlqe_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  coord_t             point_a_x,
  input  coord_t             point_a_y,
  input  coord_t             point_a_z,
  input  coord_t             point_b_x,
  input  coord_t             point_b_y,
  input  coord_t             point_b_z,
  output logic               out_valid,
  input  logic               out_stall,
  output coord_t             vertex_x,
  output coord_t             vertex_y,
  output coord_t             vertex_z,
  output unit_t              normal_x,
  output unit_t              normal_y,
  output unit_t              normal_z,
  output logic [1:0]         corner,
  output logic               last
);

  logic [30:0] line_thickness;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_LINE_THICKNESS) ? {1'b0, line_thickness} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_thickness <= THICK_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_LINE_THICKNESS) begin
      line_thickness <= pwdata[30:0];
    end
  end

  coord_t [2:0] pa;
  coord_t [2:0] pb;
  logic         q_full;
  logic         q_empty;
  logic         push;
  logic         pop;
  seg_t         wseg;
  seg_t         rseg;
  coord_t [2:0] vertex;
  unit_t  [2:0] normal;

  assign pa = {point_a_z, point_a_y, point_a_x};
  assign pb = {point_b_z, point_b_y, point_b_x};

  tlqe_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pa        (pa),
    .pb        (pb),
    .thickness (line_thickness),
    .q_full    (q_full),
    .push      (push),
    .seg       (wseg)
  );

  tlqe_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wseg),
    .full  (q_full),
    .pop   (pop),
    .rdata (rseg),
    .empty (q_empty)
  );

  tlqe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (rseg),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .vertex    (vertex),
    .normal    (normal),
    .corner    (corner),
    .last      (last)
  );

  assign vertex_x = vertex[0];
  assign vertex_y = vertex[1];
  assign vertex_z = vertex[2];
  assign normal_x = normal[0];
  assign normal_y = normal[1];
  assign normal_z = normal[2];

endmodule
